// File: rtl/lora_frame_airtime_estimator_unit_assert.svh
`ifndef LORA_FRAME_AIRTIME_ESTIMATOR_UNIT_ASSERT_SVH
`define LORA_FRAME_AIRTIME_ESTIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define LFAE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define LFAE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/lfae_pkg.sv
`default_nettype none

package lfae_pkg;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_ZERO_LEN = 2'd1;
	localparam logic [1:0] ST_BAD_FRAG = 2'd2;

	localparam logic [2:0] REG_SF   = 3'd0;
	localparam logic [2:0] REG_BW   = 3'd1;
	localparam logic [2:0] REG_CR   = 3'd2;
	localparam logic [2:0] REG_CRC  = 3'd3;
	localparam logic [2:0] REG_PRE  = 3'd4;
	localparam logic [2:0] REG_FMAX = 3'd5;

	localparam logic [19:0] BW_LDRO_MAX  = 20'd125000;
	localparam logic [8:0]  PKT_OVERHEAD = 9'd13;
	localparam logic [31:0] US_PER_S     = 32'd1000000;
	// ceil(2^41 / 1000): exact floor(v/1000) for v < 2^31
	localparam logic [31:0] MS_RECIP     = 32'd2199023256;
	// 1000 * 2^32: at or above this the packet ms saturates
	localparam logic [41:0] MS_SAT_LIMIT = 42'd4294967296000;

	typedef struct packed {
		logic        ok;
		logic [3:0]  sf;
		logic [3:0]  den;
		logic [16:0] recip;
		logic [3:0]  cr_mul;
		logic [4:0]  crc_bits;
		logic [16:0] pre_sym;
		logic [31:0] sym_us;
	} pkt_cfg_t;

	typedef struct packed {
		logic       vld;
		logic [1:0] st;
		logic [4:0] cnt;
		logic [7:0] mul;
	} side_t;

	// ceil(2^16 / den) for the divisors that can occur
	function automatic logic [16:0] den_recip(input logic [3:0] den);
		unique case (den)
			4'd5:    return 17'd13108;
			4'd6:    return 17'd10923;
			4'd7:    return 17'd9363;
			4'd8:    return 17'd8192;
			4'd9:    return 17'd7282;
			4'd10:   return 17'd6554;
			4'd11:   return 17'd5958;
			4'd12:   return 17'd5462;
			default: return 17'd0;
		endcase
	endfunction

	// six restoring division steps: returns {quotient bits, remainder}
	function automatic logic [13:0] div_step6(input logic [7:0] rem_in,
			input logic [5:0] bits, input logic [7:0] dvs);
		logic [8:0] r;
		logic [5:0] q;
		r = {1'b0, rem_in};
		q = 6'd0;
		for (int i = 5; i >= 0; i--) begin
			r = {r[7:0], bits[i]};
			if (r >= {1'b0, dvs}) begin
				r = r - {1'b0, dvs};
				q[i] = 1'b1;
			end
		end
		return {q, r[7:0]};
	endfunction

endpackage

`default_nettype wire

// File: rtl/lfae_if.sv
`default_nettype none

interface lfae_in_if;
	logic        valid;
	logic        ready;
	logic [11:0] frame_bytes;
	modport source (output valid, output frame_bytes, input ready);
	modport sink (input valid, input frame_bytes, output ready);
endinterface

interface lfae_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [4:0]  frag_total;
	logic [31:0] air_ms;
	modport source (output valid, output status, output frag_total,
		output air_ms, input ready);
	modport sink (input valid, input status, input frag_total,
		input air_ms, output ready);
endinterface

`default_nettype wire

// File: rtl/lfae_sym_div.sv
`default_nettype none

module lfae_sym_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [3:0]  sf,
	input  wire logic [19:0] bw,
	output logic             busy,
	output logic [31:0]      sym_us
);
	typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN} state_t;

	state_t      state_q;
	logic [20:0] rem_q;
	logic [31:0] quo_q;
	logic [4:0]  cnt_q;
	logic [31:0] sym_q;

	logic [34:0] num_w;
	logic [20:0] rem_sh;
	logic        ge;
	logic [20:0] rem_nx;
	logic [31:0] quo_nx;

	assign num_w  = 35'(lfae_pkg::US_PER_S) << sf;
	assign rem_sh = {rem_q[19:0], quo_q[31]};
	assign ge     = rem_sh >= {1'b0, bw};
	assign rem_nx = ge ? rem_sh - {1'b0, bw} : rem_sh;
	assign quo_nx = {quo_q[30:0], ge};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_LOAD;
			cnt_q   <= 5'd0;
		end else if (start) begin
			state_q <= S_LOAD;
		end else begin
			unique case (state_q)
				S_IDLE: begin
				end
				S_LOAD: begin
					rem_q   <= 21'd0;
					quo_q   <= num_w[31:0];
					cnt_q   <= 5'd0;
					state_q <= S_RUN;
				end
				S_RUN: begin
					rem_q <= rem_nx;
					quo_q <= quo_nx;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd31) begin
						// round up to whole microseconds
						sym_q   <= quo_nx + 32'(rem_nx != 21'd0);
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign busy   = state_q != S_IDLE;
	assign sym_us = sym_q;

endmodule

`default_nettype wire

// File: rtl/lfae_pkt_time.sv
`default_nettype none

module lfae_pkt_time (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [8:0]          pkt_len,
	input  wire lfae_pkg::pkt_cfg_t  cfg,
	output logic [31:0]              ms
);
	logic [12:0] term;
	logic [10:0] x_w;
	logic [10:0] xd_w;
	logic [10:0] blocks;
	logic [50:0] tot;
	logic [11:0] q1;
	logic [20:0] r1;

	logic [27:0] prod_s1;
	logic [17:0] n_s2;
	logic [49:0] prod_s3;
	logic [41:0] x_s4;
	logic        sat_s4;
	logic [20:0] hi_s5;
	logic [20:0] lo_s5;
	logic [52:0] ph_s5;
	logic        sat_s5;
	logic [11:0] q1_s6;
	logic [30:0] v2_s6;
	logic        sat_s6;
	logic [62:0] pl_s7;
	logic [11:0] q1_s7;
	logic        sat_s7;
	logic [31:0] ms_s8;

	// payload bits term; positive for every valid sf
	assign term = 13'({pkt_len, 3'b000}) + 13'd28 + 13'(cfg.crc_bits)
		- 13'({cfg.sf, 2'b00});
	assign x_w  = term[12:2] + 11'(|term[1:0]);
	assign xd_w = x_w + 11'(cfg.den) - 11'd1;
	assign blocks = prod_s1[26:16];
	assign tot  = 51'(prod_s3) + 51'(cfg.sym_us[31:2]) + 51'd999;
	assign q1   = ph_s5[52:41];
	// hi - q1*1000 with 1000 = 1024 - 16 - 8
	assign r1   = hi_s5 - (21'(q1) << 10) + (21'(q1) << 4) + (21'(q1) << 3);

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= 28'(xd_w) * 28'(cfg.recip);
			n_s2    <= 18'(cfg.pre_sym) + 18'd8 + 18'(blocks) * 18'(cfg.cr_mul);
			prod_s3 <= 50'(cfg.sym_us) * 50'(n_s2);
			x_s4    <= tot[41:0];
			sat_s4  <= tot >= 51'(lfae_pkg::MS_SAT_LIMIT);
			hi_s5   <= x_s4[41:21];
			lo_s5   <= x_s4[20:0];
			ph_s5   <= 53'(x_s4[41:21]) * 53'(lfae_pkg::MS_RECIP);
			sat_s5  <= sat_s4;
			q1_s6   <= q1;
			v2_s6   <= {r1[9:0], lo_s5};
			sat_s6  <= sat_s5;
			pl_s7   <= 63'(v2_s6) * 63'(lfae_pkg::MS_RECIP);
			q1_s7   <= q1_s6;
			sat_s7  <= sat_s6;
			if (!cfg.ok)
				ms_s8 <= 32'd0;
			else if (sat_s7)
				ms_s8 <= 32'hFFFF_FFFF;
			else
				ms_s8 <= {q1_s7[10:0], pl_s7[61:41]};
		end
	end

	assign ms = ms_s8;

endmodule

`default_nettype wire

// File: rtl/lora_frame_airtime_estimator_unit.sv
// LoRa frame airtime estimator.
// frame (sink): one request carries frame_bytes in bytes. result (source): one
// request per frame with status, frag_total and summed air_ms.
// Config: cfg_we/cfg_idx/cfg_wdata write one register per cycle; the user must
// write only while no frame is in flight, as the block does not enforce it.
// Any write restarts the symbol-time divider. Throughput: one frame per cycle
// once the divider is done and while no result waits on result.ready. A frame
// passes 2 stages of fragment count division, 8 stages of packet time and 2
// stages of sum and saturate. Symbol time ceil(2^sf * 1e6 / bw) is computed by
// a bit-serial divider; frame.ready is low while it runs after reset or a write.
// Two packet lanes run side by side: one for a full fragment, one for the
// last fragment; total = (count - 1) * full + last, saturating at 32 bits.
// Reset clears all valid bits and loads the register defaults (sf 7,
// bw 125000, cr 5, crc on, preamble 8, fragment max 242).
// When result.ready is low with a result held, the whole pipeline freezes
// and frame.ready drops; nothing is dropped or repeated.
`default_nettype none
`include "lora_frame_airtime_estimator_unit_assert.svh"

module lora_frame_airtime_estimator_unit #(
	parameter int MAX_FRAGMENTS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [19:0] cfg_wdata,
	lfae_in_if.sink          frame,
	lfae_out_if.source       result
);
	localparam int SIDE_DEPTH = 8; // matches packet lane latency

	// config registers
	logic [3:0]  sf_q;
	logic [19:0] bw_q;
	logic [3:0]  cr_q;
	logic        crc_q;
	logic [15:0] pre_q;
	logic [7:0]  fmax_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q   <= 4'd7;
			bw_q   <= 20'd125000;
			cr_q   <= 4'd5;
			crc_q  <= 1'b1;
			pre_q  <= 16'd8;
			fmax_q <= 8'd242;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				lfae_pkg::REG_SF:   sf_q   <= cfg_wdata[3:0];
				lfae_pkg::REG_BW:   bw_q   <= cfg_wdata;
				lfae_pkg::REG_CR:   cr_q   <= cfg_wdata[3:0];
				lfae_pkg::REG_CRC:  crc_q  <= cfg_wdata[0];
				lfae_pkg::REG_PRE:  pre_q  <= cfg_wdata[15:0];
				lfae_pkg::REG_FMAX: fmax_q <= cfg_wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// symbol time, recomputed after every config write
	logic        sym_busy;
	logic [31:0] sym_us;

	lfae_sym_div u_sym (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cfg_we),
		.sf     (sf_q),
		.bw     (bw_q),
		.busy   (sym_busy),
		.sym_us (sym_us)
	);

	// per-packet constants derived from config
	lfae_pkg::pkt_cfg_t pcfg;
	logic               ldro;

	assign ldro          = (sf_q >= 4'd11) && (bw_q <= lfae_pkg::BW_LDRO_MAX);
	assign pcfg.ok       = (bw_q != 20'd0) && (sf_q >= 4'd5) && (sf_q <= 4'd12);
	assign pcfg.sf       = sf_q;
	assign pcfg.den      = sf_q - {2'b00, ldro, 1'b0};
	assign pcfg.recip    = lfae_pkg::den_recip(pcfg.den);
	assign pcfg.cr_mul   = (cr_q > 4'd4) ? cr_q : 4'd5; // offset + 4
	assign pcfg.crc_bits = crc_q ? 5'd16 : 5'd0;
	assign pcfg.pre_sym  = 17'(pre_q) + 17'd4;
	assign pcfg.sym_us   = sym_us;

	// global advance: freeze everything while a result waits
	logic pipe_en;
	logic acc;
	logic out_vld_q;

	assign pipe_en     = !out_vld_q || result.ready;
	assign frame.ready = pipe_en && !sym_busy;
	assign acc         = frame.valid && frame.ready;

	// s1/s2: (len - 1) / fmax, six quotient bits per stage
	logic [11:0] nm;
	logic [13:0] d1_w;
	logic [13:0] d2_w;
	logic [11:0] qm;

	logic        vld_s1;
	logic        zero_s1;
	logic [5:0]  qhi_s1;
	logic [7:0]  rem_s1;
	logic [5:0]  nlo_s1;

	logic        vld_s2;
	logic [1:0]  st_s2;
	logic [4:0]  cnt_s2;
	logic [7:0]  mul_s2;
	logic [8:0]  pl_last_s2;

	assign nm   = frame.frame_bytes - 12'd1;
	assign d1_w = lfae_pkg::div_step6(8'd0, nm[11:6], fmax_q);
	assign d2_w = lfae_pkg::div_step6(rem_s1, nlo_s1, fmax_q);
	assign qm   = {qhi_s1, d2_w[13:8]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (pipe_en) begin
			vld_s1 <= acc;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			zero_s1 <= frame.frame_bytes == 12'd0;
			qhi_s1  <= d1_w[13:8];
			rem_s1  <= d1_w[7:0];
			nlo_s1  <= nm[5:0];
			// zero length is checked first
			if (zero_s1)
				st_s2 <= lfae_pkg::ST_ZERO_LEN;
			else if (fmax_q == 8'd0 || qm >= 12'(MAX_FRAGMENTS))
				st_s2 <= lfae_pkg::ST_BAD_FRAG;
			else
				st_s2 <= lfae_pkg::ST_OK;
			cnt_s2     <= 5'(qm + 12'd1);
			mul_s2     <= qm[7:0];
			// last fragment carries remainder + 1 bytes
			pl_last_s2 <= 9'(d2_w[7:0]) + 9'd1 + lfae_pkg::PKT_OVERHEAD;
		end
	end

	// packet lanes: full fragment and last fragment
	logic [8:0]  pl_full;
	logic [31:0] ms_full;
	logic [31:0] ms_last;

	assign pl_full = 9'(fmax_q) + lfae_pkg::PKT_OVERHEAD;

	lfae_pkt_time u_full (
		.clk     (clk),
		.en      (pipe_en),
		.pkt_len (pl_full),
		.cfg     (pcfg),
		.ms      (ms_full)
	);

	lfae_pkt_time u_last (
		.clk     (clk),
		.en      (pipe_en),
		.pkt_len (pl_last_s2),
		.cfg     (pcfg),
		.ms      (ms_last)
	);

	// side data that rides along with the lanes (stages 3..10)
	lfae_pkg::side_t sb_pipe_s10 [SIDE_DEPTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SIDE_DEPTH; i++)
				sb_pipe_s10[i] <= '0;
		end else if (pipe_en) begin
			sb_pipe_s10[0] <= '{vld: vld_s2, st: st_s2, cnt: cnt_s2, mul: mul_s2};
			for (int i = 1; i < SIDE_DEPTH; i++)
				sb_pipe_s10[i] <= sb_pipe_s10[i-1];
		end
	end

	// s11: (count - 1) * full; out: + last, saturate, zero on error
	logic        vld_s11;
	logic [1:0]  st_s11;
	logic [4:0]  cnt_s11;
	logic [39:0] prod_s11;
	logic [31:0] last_s11;
	logic [40:0] sum_w;

	logic [1:0]  out_st_q;
	logic [4:0]  out_cnt_q;
	logic [31:0] out_air_q;

	assign sum_w = 41'(prod_s11) + 41'(last_s11);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11   <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (pipe_en) begin
			vld_s11   <= sb_pipe_s10[SIDE_DEPTH-1].vld;
			out_vld_q <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			st_s11   <= sb_pipe_s10[SIDE_DEPTH-1].st;
			cnt_s11  <= sb_pipe_s10[SIDE_DEPTH-1].cnt;
			prod_s11 <= 40'(sb_pipe_s10[SIDE_DEPTH-1].mul) * 40'(ms_full);
			last_s11 <= ms_last;
			out_st_q <= st_s11;
			if (st_s11 != lfae_pkg::ST_OK) begin
				out_cnt_q <= 5'd0;
				out_air_q <= 32'd0;
			end else begin
				out_cnt_q <= cnt_s11;
				out_air_q <= (sum_w > 41'h0_FFFF_FFFF) ? 32'hFFFF_FFFF : sum_w[31:0];
			end
		end
	end

	assign result.valid      = out_vld_q;
	assign result.status     = out_st_q;
	assign result.frag_total = out_cnt_q;
	assign result.air_ms     = out_air_q;

	`LFAE_ASSERT_IMP(a_no_take_busy, frame.valid && frame.ready, !sym_busy,
		"frame taken while symbol time is stale")
	`LFAE_ASSERT_NXT(a_cfg_restarts, cfg_we, sym_busy,
		"config write did not restart symbol divider")
	`LFAE_ASSERT_IMP(a_err_zero,
		out_vld_q && (out_st_q != lfae_pkg::ST_OK),
		(out_cnt_q == 5'd0) && (out_air_q == 32'd0),
		"error result carries nonzero count or airtime")
	`LFAE_ASSERT_NXT(a_stall_freeze, !pipe_en,
		$stable(vld_s1) && $stable(vld_s2) && $stable(vld_s11),
		"pipeline moved during a stall")

endmodule

`default_nettype wire
